[sv/set_assoc_cache_tag_lru_assert.svh]
// Assertion macros shared by the set-associative tag store modules.
// No dependencies; included by the modules that check their own logic.
`ifndef SET_ASSOC_CACHE_TAG_LRU_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LRU_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SACTL_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SACTL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sactl_pkg.sv]
// Shared types and constants of the set-associative tag store with LRU replacement.
// No dependencies; imported by every module of the block.
package sactl_pkg;

    // Address layout: 4-byte words, 32-bit byte address, tag limited to 30 bits.
    localparam int ADDR_W        = 32;
    localparam int TAG_W         = 30;
    localparam int BYTE_OFF_BITS = 2;

    // The index field is at most 15 bits wide (index_bits is a 4-bit register).
    localparam int IDX_FIELD_W = 15;
    // Reciprocal multiplier width for the set modulo; product fits in 32 bits.
    localparam int MULT_W      = 17;

    // Configuration register widths and port shape.
    localparam int BOFF_W     = 3;
    localparam int IDXB_W     = 4;
    localparam int WAYSU_W    = 4;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 2;

    // Width of an effective way count (up to 16).
    localparam int WAYS_CNT_W = 5;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED    = 2'd2;

    typedef struct packed {
        logic [BOFF_W-1:0]  block_offset_bits;
        logic [IDXB_W-1:0]  index_bits;
        logic [WAYSU_W-1:0] ways_used;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        block_offset_bits: 3'd3,
        index_bits:        4'd8,
        ways_used:         4'd1
    };

endpackage

[sv/sactl_addr_split.sv]
// Address split stage: extracts the set number and tag from a byte address.
// Depends on sactl_pkg; the set modulo uses a reciprocal multiply by the set count.
module sactl_addr_split
    import sactl_pkg::*;
#(
    parameter int SETS = 256,
    parameter int SW   = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_cfg              i_cfg,
    output logic              o_vld,
    output logic [SW-1:0]     o_set,
    output logic [TAG_W-1:0]  o_tag
);

    // Exact floor division by SETS for any 15-bit value.
    localparam int MOD_SHIFT = IDX_FIELD_W + $clog2(SETS);
    localparam logic [MULT_W-1:0] MOD_MULT =
        MULT_W'(((64'd1 << MOD_SHIFT) + 64'(SETS) - 64'd1) / 64'(SETS));
    localparam logic [IDX_FIELD_W-1:0] SETS_C = IDX_FIELD_W'(SETS);

    logic [3:0]                    set_shift;
    logic [4:0]                    tag_shift;
    logic [ADDR_W-1:0]             idx_shifted;
    logic [ADDR_W-1:0]             tag_shifted;
    logic [15:0]                   idx_mask;
    logic [IDX_FIELD_W-1:0]        idx_field;
    logic [IDX_FIELD_W+MULT_W-1:0] quo_prod;
    logic [IDX_FIELD_W-1:0]        quo;
    logic [IDX_FIELD_W-1:0]        rem;

    logic                   r_vld;
    logic [IDX_FIELD_W-1:0] r_idx;
    logic [IDX_FIELD_W-1:0] r_quo;
    logic [TAG_W-1:0]       r_tag;

    // Field extraction and the quotient of the index field by the set count.
    always_comb begin
        set_shift   = 4'(BYTE_OFF_BITS) + 4'(i_cfg.block_offset_bits);
        tag_shift   = 5'(set_shift) + 5'(i_cfg.index_bits);
        idx_shifted = i_addr >> set_shift;
        tag_shifted = i_addr >> tag_shift;
        idx_mask    = (16'd1 << i_cfg.index_bits) - 16'd1;
        idx_field   = idx_shifted[IDX_FIELD_W-1:0] & idx_mask[IDX_FIELD_W-1:0];
        quo_prod    = (IDX_FIELD_W + MULT_W)'(idx_field) * (IDX_FIELD_W + MULT_W)'(MOD_MULT);
        quo         = IDX_FIELD_W'(quo_prod >> MOD_SHIFT);
    end

    // Stage register between the split and the remainder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= idx_field;
        r_quo <= quo;
        r_tag <= tag_shifted[TAG_W-1:0];
    end

    // The remainder is below SETS, so it fits the set index.
    always_comb begin
        rem = r_idx - (r_quo * SETS_C);
    end

    assign o_vld = r_vld;
    assign o_set = rem[SW-1:0];
    assign o_tag = r_tag;

endmodule

[sv/sactl_tag_ram.sv]
// Tag store memory: one row per set holding valid, tag and rank of every way.
// Depends on sactl_pkg and the assertion macros; clears itself after reset.
`include "set_assoc_cache_tag_lru_assert.svh"

module sactl_tag_ram
    import sactl_pkg::*;
#(
    parameter int SETS  = 256,
    parameter int SW    = 8,
    parameter int RW    = 3,
    parameter int WAYS  = 8,
    parameter int ROW_W = 8 * (1 + 30 + 3)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [SW-1:0]    i_rd_set,
    output logic [ROW_W-1:0] o_row,
    input  logic             i_wr_en,
    input  logic [SW-1:0]    i_wr_set,
    input  logic [ROW_W-1:0] i_wr_row,
    output logic             o_clearing
);

    localparam int WAY_W = 1 + TAG_W + RW;
    localparam logic [SW-1:0] CLR_LAST = SW'(SETS - 1);

    logic [ROW_W-1:0] reset_row;

    logic [ROW_W-1:0] r_mem [SETS];
    logic [ROW_W-1:0] r_rd_raw;
    logic [ROW_W-1:0] r_fwd_row;
    logic             r_fwd_sel;
    logic             r_clearing;
    logic [SW-1:0]    r_clr_cnt;

    // A cleared row: no line valid, tag zero, each way ranked by its number.
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            reset_row[w*WAY_W +: WAY_W] = {1'b0, TAG_W'(0), RW'(w)};
        end
    end

    // Clearing pass over every set, one row per cycle, after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == CLR_LAST) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Memory write port: the clearing pass or a line update.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_cnt] <= reset_row;
        end else if (i_wr_en) begin
            r_mem[i_wr_set] <= i_wr_row;
        end
    end

    // Registered read, with the row being written in the same cycle forwarded.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_raw  <= r_mem[i_rd_set];
            r_fwd_row <= i_wr_row;
            r_fwd_sel <= i_wr_en && (i_wr_set == i_rd_set);
        end
    end

    assign o_row      = r_fwd_sel ? r_fwd_row : r_rd_raw;
    assign o_clearing = r_clearing;

    // Lookups never overlap the clearing pass, and the pass walks every set in order.
    `SACTL_ASSERT_IMPLY(a_no_read_in_clear, i_clk, i_rst_n, i_rd_en, !r_clearing,
        "tag store read during the clearing pass")
    `SACTL_ASSERT_NEXT(a_clear_walks_sets, i_clk, i_rst_n,
        (r_clearing && (r_clr_cnt != CLR_LAST)),
        (r_clearing && (r_clr_cnt == ($past(r_clr_cnt) + 1'b1))),
        "clearing pass stopped or skipped a set")

endmodule

[sv/sactl_way_update.sv]
// Way compare and LRU update for one set row: hit detection, victim choice, rank aging.
// Depends on sactl_pkg; purely combinational, all ways side by side.
module sactl_way_update
    import sactl_pkg::*;
#(
    parameter int WAYS  = 8,
    parameter int RW    = 3,
    parameter int ROW_W = 8 * (1 + 30 + 3)
) (
    input  logic [ROW_W-1:0]   i_row,
    input  logic [TAG_W-1:0]   i_tag,
    input  logic [WAYSU_W-1:0] i_ways_used,
    output logic               o_hit,
    output logic [ROW_W-1:0]   o_row,
    output logic [WAYS-1:0]    o_touch
);

    localparam int WAY_W = 1 + TAG_W + RW;

    logic [WAYS_CNT_W-1:0] ways_eff;
    logic                  way_valid [WAYS];
    logic [TAG_W-1:0]      way_tag   [WAYS];
    logic [RW-1:0]         way_rank  [WAYS];
    logic [WAYS-1:0]       in_use;
    logic [WAYS-1:0]       match;
    logic [WAYS-1:0]       empty;
    logic [WAYS-1:0]       lru;
    logic [WAYS-1:0]       cand;
    logic [WAYS-1:0]       touch;
    logic [RW-1:0]         old_rank;
    logic                  hit;

    // Effective associativity: zero acts as one, too large acts as WAYS.
    always_comb begin
        if (i_ways_used == '0) begin
            ways_eff = WAYS_CNT_W'(1);
        end else if (WAYS_CNT_W'(i_ways_used) > WAYS_CNT_W'(WAYS)) begin
            ways_eff = WAYS_CNT_W'(WAYS);
        end else begin
            ways_eff = WAYS_CNT_W'(i_ways_used);
        end
    end

    // Unpack the row and classify each way.
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            way_valid[w] = i_row[w*WAY_W + WAY_W - 1];
            way_tag[w]   = i_row[w*WAY_W + RW +: TAG_W];
            way_rank[w]  = i_row[w*WAY_W +: RW];
            in_use[w]    = WAYS_CNT_W'(w) < ways_eff;
            match[w]     = in_use[w] && way_valid[w] && (way_tag[w] == i_tag);
            empty[w]     = in_use[w] && !way_valid[w];
        end
    end

    // Least recent way: largest rank among ways in use, lowest number on a tie.
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            lru[w] = in_use[w];
            for (int v = 0; v < WAYS; v++) begin
                if (in_use[v] && (v < w) && !(way_rank[w] > way_rank[v])) begin
                    lru[w] = 1'b0;
                end
                if (in_use[v] && (v > w) && (way_rank[w] < way_rank[v])) begin
                    lru[w] = 1'b0;
                end
            end
        end
    end

    // The touched way is the lowest candidate: matching, else empty, else LRU.
    always_comb begin
        hit      = |match;
        cand     = hit ? match : ((|empty) ? empty : lru);
        touch    = cand & (~cand + WAYS'(1));
        old_rank = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (touch[w]) begin
                old_rank = way_rank[w];
            end
        end
    end

    // New row: touched way becomes most recent, younger ways in use age by one.
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            if (touch[w]) begin
                o_row[w*WAY_W +: WAY_W] = hit ? {way_valid[w], way_tag[w], RW'(0)}
                                              : {1'b1, i_tag, RW'(0)};
            end else if (in_use[w] && (way_rank[w] < old_rank)) begin
                o_row[w*WAY_W +: WAY_W] = {way_valid[w], way_tag[w], way_rank[w] + RW'(1)};
            end else begin
                o_row[w*WAY_W +: WAY_W] = {way_valid[w], way_tag[w], way_rank[w]};
            end
        end
    end

    assign o_hit   = hit;
    assign o_touch = touch;

endmodule

[sv/set_assoc_cache_tag_lru.sv]
// Top level of the set-associative tag store with LRU replacement.
// Depends on sactl_pkg, sactl_addr_split, sactl_tag_ram, sactl_way_update and the macros.
//
//   Channel    Ports                                      Transaction
//   lookup     start, busy, i_byte_address               start high while busy low
//   result     o_result_valid, o_hit                      one cycle, strobe high
//   config     i_cfg_we, i_cfg_idx, i_cfg_data            write enable high
//
// One address is accepted every cycle while busy is low; its result passes through
// the pipeline: input register, split register, tag store read
// register, then the result register written together with the updated set row.
// Back-to-back lookups of one set see each other through a forwarding path at the read.
// After reset, busy stays high while the tag store is cleared.
// Results cannot be stalled; configuration writes are taken in any cycle.
`include "set_assoc_cache_tag_lru_assert.svh"

module set_assoc_cache_tag_lru
    import sactl_pkg::*;
#(
    parameter int SETS = 256,
    parameter int WAYS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ADDR_W-1:0]     i_byte_address,
    output logic                  o_result_valid,
    output logic                  o_hit,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int RW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_W = 1 + TAG_W + RW;
    localparam int ROW_W = WAYS * WAY_W;

    logic             accept;
    logic             clearing;
    logic             s2_vld;
    logic [SW-1:0]    s2_set;
    logic [TAG_W-1:0] s2_tag;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] upd_row;
    logic [WAYS-1:0]  upd_touch;
    logic             upd_hit;

    t_cfg              r_cfg;
    logic              r_in_vld;
    logic [ADDR_W-1:0] r_in_addr;
    logic              r_s3_vld;
    logic [SW-1:0]     r_s3_set;
    logic [TAG_W-1:0]  r_s3_tag;
    logic              r_out_vld;
    logic              r_hit;

    assign busy   = clearing;
    assign accept = start && !busy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLOCK_OFFSET: r_cfg.block_offset_bits <= i_cfg_data[BOFF_W-1:0];
                CFG_INDEX_BITS:   r_cfg.index_bits        <= i_cfg_data[IDXB_W-1:0];
                CFG_WAYS_USED:    r_cfg.ways_used         <= i_cfg_data[WAYSU_W-1:0];
                default:          r_cfg                   <= r_cfg;
            endcase
        end
    end

    // Input register and pipeline valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= accept;
            r_s3_vld  <= s2_vld;
            r_out_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_addr <= i_byte_address;
        end
        r_s3_set <= s2_set;
        r_s3_tag <= s2_tag;
        r_hit    <= upd_hit;
    end

    sactl_addr_split #(
        .SETS (SETS),
        .SW   (SW)
    ) u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_addr  (r_in_addr),
        .i_cfg   (r_cfg),
        .o_vld   (s2_vld),
        .o_set   (s2_set),
        .o_tag   (s2_tag)
    );

    sactl_tag_ram #(
        .SETS  (SETS),
        .SW    (SW),
        .RW    (RW),
        .WAYS  (WAYS),
        .ROW_W (ROW_W)
    ) u_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (s2_vld),
        .i_rd_set   (s2_set),
        .o_row      (rd_row),
        .i_wr_en    (r_s3_vld),
        .i_wr_set   (r_s3_set),
        .i_wr_row   (upd_row),
        .o_clearing (clearing)
    );

    sactl_way_update #(
        .WAYS  (WAYS),
        .RW    (RW),
        .ROW_W (ROW_W)
    ) u_update (
        .i_row       (rd_row),
        .i_tag       (r_s3_tag),
        .i_ways_used (r_cfg.ways_used),
        .o_hit       (upd_hit),
        .o_row       (upd_row),
        .o_touch     (upd_touch)
    );

    assign o_result_valid = r_out_vld;
    assign o_hit          = r_hit;

    // Every result traces back to one accepted transaction, and each update touches one way.
    `SACTL_ASSERT_IMPLY(a_result_latency, i_clk, i_rst_n, o_result_valid, ($past(accept, 4)),
        "result strobe without a transaction four cycles earlier")
    `SACTL_ASSERT_IMPLY(a_one_way_touched, i_clk, i_rst_n, r_s3_vld, ($onehot(upd_touch)),
        "set update does not touch exactly one way")

endmodule

[test/set_assoc_cache_tag_lru_tb.sv]
// Self-checking testbench for the set-associative tag store with LRU replacement.
// Depends on sactl_pkg and set_assoc_cache_tag_lru; a scoreboard class keeps its own
// copy of the tag store and predicts hit or miss for every accepted lookup.
module set_assoc_cache_tag_lru_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sactl_pkg::*;

    localparam int SETS            = 256;
    localparam int WAYS            = 8;
    localparam int RANK_W          = $clog2(WAYS);
    localparam int LATENCY         = 4;
    localparam int CLK_HALF        = 4;
    localparam int LOOKUPS_PER_SET = 58;
    localparam int POOL_MAX        = 12;

    // One expected lookup result, kept with its address for messages.
    typedef struct {
        logic [ADDR_W-1:0] addr;
        bit                hit;
    } t_hit_expect;

    // Scoreboard: a shadow tag store with ranks, plus the queue of expected hits.
    class t_tag_lru_scoreboard;
        bit                line_valid [SETS][WAYS];
        logic [TAG_W-1:0]  line_tag   [SETS][WAYS];
        logic [RANK_W-1:0] line_rank  [SETS][WAYS];
        int unsigned       boff;
        int unsigned       idxb;
        int unsigned       ways_cfg;
        t_hit_expect       pending_hits[$];
        int unsigned       mismatches;
        int unsigned       lookups;
        int unsigned       hits_seen;

        function new();
            boff       = CFG_RESET.block_offset_bits;
            idxb       = CFG_RESET.index_bits;
            ways_cfg   = CFG_RESET.ways_used;
            mismatches = 0;
            lookups    = 0;
            hits_seen  = 0;
            for (int s = 0; s < SETS; s++) begin
                for (int w = 0; w < WAYS; w++) begin
                    line_valid[s][w] = 1'b0;
                    line_tag[s][w]   = '0;
                    line_rank[s][w]  = RANK_W'(w);
                end
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BLOCK_OFFSET: boff = data[BOFF_W-1:0];
                CFG_INDEX_BITS:   idxb = data[IDXB_W-1:0];
                CFG_WAYS_USED:    ways_cfg = data[WAYSU_W-1:0];
                default: ;
            endcase
        endfunction

        // The touched way becomes rank 0; younger ways in use age by one.
        function void touch_way(int unsigned set_no, int unsigned way, int unsigned n_ways);
            logic [RANK_W-1:0] old_rank;
            old_rank = line_rank[set_no][way];
            for (int unsigned w = 0; w < n_ways; w++) begin
                if (w != way && line_rank[set_no][w] < old_rank)
                    line_rank[set_no][w] = line_rank[set_no][w] + 1'b1;
            end
            line_rank[set_no][way] = '0;
        endfunction

        // Looks up one address, updates the shadow store and returns the hit flag.
        function bit lookup_tag(logic [ADDR_W-1:0] addr);
            int unsigned       set_shift;
            int unsigned       tag_shift;
            int unsigned       set_no;
            int unsigned       n_ways;
            int unsigned       victim;
            logic [ADDR_W-1:0] idx_field;
            logic [TAG_W-1:0]  tag;
            bit                found_empty;
            set_shift = BYTE_OFF_BITS + boff;
            tag_shift = set_shift + idxb;
            idx_field = (addr >> set_shift) & ((32'd1 << idxb) - 32'd1);
            set_no    = idx_field % SETS;
            tag       = TAG_W'(addr >> tag_shift);
            n_ways    = (ways_cfg == 0) ? 1 : ((ways_cfg > WAYS) ? WAYS : ways_cfg);

            // The lowest-numbered valid matching way wins.
            for (int unsigned w = 0; w < n_ways; w++) begin
                if (line_valid[set_no][w] && line_tag[set_no][w] == tag) begin
                    touch_way(set_no, w, n_ways);
                    return 1'b1;
                end
            end

            // Miss: first empty way, else the oldest, lowest number on a tie.
            victim      = 0;
            found_empty = 1'b0;
            for (int unsigned w = 0; w < n_ways; w++) begin
                if (!found_empty && !line_valid[set_no][w]) begin
                    victim      = w;
                    found_empty = 1'b1;
                end
            end
            if (!found_empty) begin
                for (int unsigned w = 1; w < n_ways; w++) begin
                    if (line_rank[set_no][w] > line_rank[set_no][victim])
                        victim = w;
                end
            end
            line_valid[set_no][victim] = 1'b1;
            line_tag[set_no][victim]   = tag;
            touch_way(set_no, victim, n_ways);
            return 1'b0;
        endfunction

        function void note_lookup(logic [ADDR_W-1:0] addr);
            t_hit_expect e;
            e.addr = addr;
            e.hit  = lookup_tag(addr);
            pending_hits.push_back(e);
            lookups++;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t ns] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic hit);
            t_hit_expect e;
            if (pending_hits.size() == 0) begin
                report_mismatch($sformatf("result hit=%0b with no lookup outstanding", hit));
            end else begin
                e = pending_hits.pop_front();
                if (hit === 1'b1)
                    hits_seen++;
                if (hit !== e.hit)
                    report_mismatch($sformatf("address %08h: hit=%0b, expected %0b",
                                              e.addr, hit, e.hit));
            end
        endtask

        task check_drained();
            if (pending_hits.size() != 0)
                report_mismatch($sformatf("%0d lookups never returned a result",
                                          pending_hits.size()));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [ADDR_W-1:0]     i_byte_address;
    logic                  o_result_valid;
    logic                  o_hit;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_tag_lru_scoreboard sb = new();
    int unsigned         idle_pct;
    int unsigned         settings_used;
    logic [ADDR_W-1:0]   tag_pool [POOL_MAX];
    int unsigned         pool_size;

    set_assoc_cache_tag_lru #(
        .SETS(SETS),
        .WAYS(WAYS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_byte_address (i_byte_address),
        .o_result_valid (o_result_valid),
        .o_hit          (o_hit),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hard limit on the run in case the block stops answering.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Every result strobe is checked against the oldest expected hit.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_result(o_hit);
    end

    // Drives one lookup transaction after a random idle gap; returns at a falling edge.
    task automatic send_lookup(input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start          <= 1'b1;
        i_byte_address <= addr;
        do @(posedge i_clk); while (busy);
        sb.note_lookup(addr);
        @(negedge i_clk);
    endtask

    // Waits for the pipeline to drain, then writes all three registers.
    task automatic apply_config(int unsigned b, int unsigned x, int unsigned w);
        logic [CFG_IDX_W-1:0] regs [3];
        int unsigned          vals [3];
        regs  = '{CFG_BLOCK_OFFSET, CFG_INDEX_BITS, CFG_WAYS_USED};
        vals  = '{b, x, w};
        start <= 1'b0;
        while (sb.pending_hits.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
        for (int k = 0; k < 3; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[k];
            i_cfg_data <= CFG_DATA_W'(vals[k]);
            sb.write_reg(regs[k], CFG_DATA_W'(vals[k]));
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly addresses from a few sets and a small tag pool, so that lines get
    // reused and evicted; the rest is fully random.
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned       set_shift;
        int unsigned       tag_shift;
        logic [ADDR_W-1:0] idx_field;
        logic [ADDR_W-1:0] low_bits;
        if ($urandom_range(0, 99) < 20)
            return $urandom();
        set_shift = BYTE_OFF_BITS + sb.boff;
        tag_shift = set_shift + sb.idxb;
        idx_field = $urandom_range(0, 3);
        // Bits above the store's set count wrap onto the same set.
        if ($urandom_range(0, 3) == 0)
            idx_field = idx_field | (32'd1 << $urandom_range(8, 14));
        idx_field = idx_field & ((32'd1 << sb.idxb) - 32'd1);
        low_bits  = $urandom() & ((32'd1 << set_shift) - 32'd1);
        return (tag_pool[$urandom_range(0, pool_size - 1)] << tag_shift)
             | (idx_field << set_shift) | low_bits;
    endfunction

    initial begin
        int unsigned       boff_plan [7];
        int unsigned       idxb_plan [7];
        int unsigned       ways_plan [7];
        int unsigned       idle_plan [7];
        logic [ADDR_W-1:0] reset_cfg_addrs [6];
        logic [ADDR_W-1:0] wide_cfg_addrs [4];
        int unsigned       n_ways;
        int                k;

        boff_plan       = '{0, 7, 2, 5, 3, 1, 6};
        idxb_plan       = '{0, 15, 4, 8, 2, 11, 1};
        ways_plan       = '{8, 15, 0, 2, 4, 1, 3};
        idle_plan       = '{0, 86, 0, 14, 86, 0, 14};
        reset_cfg_addrs = '{32'h0000_0000, 32'h0000_0000,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'h0000_2000, 32'h0000_0000};
        wide_cfg_addrs  = '{32'h0000_0000, 32'h0002_0000,
                            32'hFFFF_FFFF, 32'hFF00_0000};

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_byte_address = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_BLOCK_OFFSET;
        i_cfg_data     = '0;
        idle_pct       = 0;
        settings_used  = 1;
        pool_size      = 1;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, direct mapped: repeats hit, a same-set tag evicts.
        foreach (reset_cfg_addrs[i])
            send_lookup(reset_cfg_addrs[i]);

        // Widest block offset and index, oversized way count; wrapped index bits alias.
        apply_config(7, 15, 15);
        foreach (wide_cfg_addrs[i])
            send_lookup(wide_cfg_addrs[i]);

        // One set, eight ways: nine tags force an LRU eviction, then the first returns.
        apply_config(0, 0, 8);
        for (int t = 1; t <= 9; t++)
            send_lookup(ADDR_W'(t) << BYTE_OFF_BITS);
        send_lookup(ADDR_W'(1) << BYTE_OFF_BITS);

        // Zero ways acts as one; the refill duplicates a tag held in a higher way,
        // and widening again must hit on the lowest matching way.
        apply_config(0, 0, 0);
        send_lookup(ADDR_W'(5) << BYTE_OFF_BITS);
        apply_config(0, 0, 8);
        send_lookup(ADDR_W'(5) << BYTE_OFF_BITS);

        // Random phases, each with its own register setting and sender idling.
        for (int p = 0; p < 7; p++) begin
            apply_config(boff_plan[p], idxb_plan[p], ways_plan[p]);
            idle_pct  = idle_plan[p];
            n_ways    = (ways_plan[p] == 0) ? 1
                      : ((ways_plan[p] > WAYS) ? WAYS : ways_plan[p]);
            pool_size = n_ways + 3;
            for (int i = 0; i < POOL_MAX; i++)
                tag_pool[i] = (i % 2 == 0) ? ADDR_W'(i) : $urandom();
            repeat (LOOKUPS_PER_SET) send_lookup(pick_address());
        end
        start <= 1'b0;

        // Drain outstanding results, then watch for stray strobes.
        for (k = 0; k < 4000 && sb.pending_hits.size() != 0; k++)
            @(negedge i_clk);
        repeat (2 * LATENCY + 4) @(negedge i_clk);
        sb.check_drained();

        $display("Ran %0d lookups (%0d hits, %0d misses) under %0d register settings,",
                 sb.lookups, sb.hits_seen, sb.lookups - sb.hits_seen, settings_used);
        $display("with sender idling between none and 86 of 100 cycles.");
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
